// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to leave them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/bfdt_pkg.sv =====
// ---------------------------------------------------------------------------
// bfdt_pkg
// Types and constants shared by the fixed-point to decimal text formatter.
// ---------------------------------------------------------------------------
package bfdt_pkg;

    localparam int VALUE_W             = 64;
    localparam int SCALE_W             = 6;
    localparam int CHAR_W              = 8;
    localparam int BCD_DIGITS          = 20;
    localparam int BCD_W               = 4 * BCD_DIGITS;
    localparam int IDX_W               = $clog2(BCD_DIGITS);
    localparam int BIT_CNT_W           = $clog2(VALUE_W);
    localparam int MAX_FRACTION_DIGITS = 60;
    localparam int FCNT_W              = $clog2(MAX_FRACTION_DIGITS);
    localparam int QUEUE_DEPTH         = 2;
    localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] int_part;
        logic [VALUE_W-1:0] frac;
    } t_entry;

endpackage

// ===== design/bfdt_front.sv =====
// ---------------------------------------------------------------------------
// bfdt_front
// Splits each number into sign, integer part and left-aligned fraction,
// and holds the results in a short queue for the formatter.
// ---------------------------------------------------------------------------
module bfdt_front
    import bfdt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic        [SCALE_W-1:0] i_scale,
    output logic                      o_q_valid,
    output t_entry                    o_q_entry,
    input  logic                      i_q_pop
);

    logic [VALUE_W-1:0] mag;
    logic [SCALE_W:0]   frac_sh;
    t_entry             entry;
    logic               push_ok;
    logic               pop_ok;

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    always_comb begin
        mag = i_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(i_value)) : $unsigned(i_value);
        frac_sh = (SCALE_W + 1)'(VALUE_W) - {1'b0, i_scale};
        entry.neg      = i_value[VALUE_W-1];
        entry.int_part = mag >> i_scale;
        entry.frac     = mag << frac_sh;
    end

    assign full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_entry = r_mem[r_rptr];
    assign push_ok   = push && !full;
    assign pop_ok    = i_q_pop && o_q_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push_ok) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop_ok) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= entry;
        end
    end

endmodule

// ===== design/bfdt_back.sv =====
// ---------------------------------------------------------------------------
// bfdt_back
// Converts the integer part to BCD by shift-and-add-3, then emits the sign,
// integer digits, point, fraction digits, one character per cycle if popped.
// ---------------------------------------------------------------------------
module bfdt_back
    import bfdt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_entry            i_q_entry,
    output logic              o_q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [CHAR_W-1:0] o_text_char,
    output logic              o_last
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CONV = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_SIGN = 7'b0001000,
        S_INT  = 7'b0010000,
        S_DOT  = 7'b0100000,
        S_FRAC = 7'b1000000
    } t_state;

    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    t_state                r_state, n_state;
    logic                  r_neg, n_neg;
    logic [VALUE_W-1:0]    r_bin, n_bin;
    logic [VALUE_W-1:0]    r_frac, n_frac;
    t_bcd                  r_bcd, n_bcd;
    logic [BIT_CNT_W-1:0]  r_bitcnt, n_bitcnt;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [FCNT_W-1:0]     r_fcnt, n_fcnt;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    t_bcd                  bcd_adj;
    logic [BCD_W-1:0]      bcd_flat;
    logic [IDX_W-1:0]      top_idx;
    logic [VALUE_W+3:0]    frac_x10;
    logic                  frac_done;
    logic                  out_ready;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        bcd_flat = bcd_adj;
        top_idx  = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                top_idx = IDX_W'(i);
            end
        end
        frac_x10  = ({4'd0, r_frac} << 3) + ({4'd0, r_frac} << 1);
        frac_done = (frac_x10[VALUE_W-1:0] == '0)
                 || (r_fcnt == FCNT_W'(MAX_FRACTION_DIGITS - 1));
    end

    assign out_ready = !r_out_valid || pop;

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_frac      = r_frac;
        n_bcd       = r_bcd;
        n_bitcnt    = r_bitcnt;
        n_idx       = r_idx;
        n_fcnt      = r_fcnt;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        o_q_pop     = 1'b0;

        if (r_out_valid && pop) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_neg    = i_q_entry.neg;
                    n_bin    = i_q_entry.int_part;
                    n_frac   = i_q_entry.frac;
                    n_bcd    = '0;
                    n_bitcnt = '0;
                    n_state  = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd    = {bcd_flat[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin    = r_bin << 1;
                n_bitcnt = r_bitcnt + 1'b1;
                if (r_bitcnt == BIT_CNT_W'(VALUE_W - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx   = top_idx;
                n_state = r_neg ? S_SIGN : S_INT;
            end
            S_SIGN: begin
                if (out_ready) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_INT;
                end
            end
            S_INT: begin
                if (out_ready) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_ZERO + {4'd0, r_bcd[r_idx]};
                    n_last      = (r_idx == '0) && (r_frac == '0);
                    if (r_idx == '0) begin
                        n_state = (r_frac != '0) ? S_DOT : S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            S_DOT: begin
                if (out_ready) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_DOT;
                    n_last      = 1'b0;
                    n_fcnt      = '0;
                    n_state     = S_FRAC;
                end
            end
            S_FRAC: begin
                if (out_ready) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_ZERO + {4'd0, frac_x10[VALUE_W+3:VALUE_W]};
                    n_last      = frac_done;
                    n_frac      = frac_x10[VALUE_W-1:0];
                    n_fcnt      = r_fcnt + 1'b1;
                    if (frac_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_bin    <= n_bin;
        r_frac   <= n_frac;
        r_bcd    <= n_bcd;
        r_bitcnt <= n_bitcnt;
        r_idx    <= n_idx;
        r_fcnt   <= n_fcnt;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign empty       = !r_out_valid;
    assign o_text_char = r_char;
    assign o_last      = r_last;

endmodule

// ===== design/binary_fixed_point_to_decimal_text.sv =====
// ---------------------------------------------------------------------------
// binary_fixed_point_to_decimal_text
// Prints value / 2^scale as decimal ASCII text, fraction cut at 60 digits,
// one character per transaction, final character of each number marked.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         push / full          i_value, i_scale
//  result    out        empty / pop          o_text_char, o_last
//
//  Before its first character an item is taken from the queue, passed through
//  the shift-and-add-3 unit bit by bit and scanned for the top digit. Then it
//  emits 1 to 63 characters, one per cycle while the output is popped.
//  A two-entry queue takes new items while the formatter is busy.
//  A stalled result holds in the output register and stops the formatter.
//  Reset empties the queue and the output register.
// ---------------------------------------------------------------------------
module binary_fixed_point_to_decimal_text
    import bfdt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic        [SCALE_W-1:0] i_scale,
    output logic                      empty,
    input  logic                      pop,
    output logic        [CHAR_W-1:0]  o_text_char,
    output logic                      o_last
);

`include "assert_macros.svh"

    logic   q_valid;
    logic   q_pop;
    t_entry q_entry;
    logic   char_legal;

    bfdt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_value   (i_value),
        .i_scale   (i_scale),
        .o_q_valid (q_valid),
        .o_q_entry (q_entry),
        .i_q_pop   (q_pop)
    );

    bfdt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

    assign char_legal = (o_text_char == CHAR_MINUS) || (o_text_char == CHAR_DOT)
                     || ((o_text_char >= CHAR_ZERO) && (o_text_char <= CHAR_NINE));

    `ASSERT_IMPLY(a_full_has_entry, i_clk, i_rst_n, full, q_valid)
    `ASSERT_IMPLY(a_pop_needs_entry, i_clk, i_rst_n, q_pop, q_valid)
    `ASSERT_IMPLY(a_legal_char, i_clk, i_rst_n, !empty, char_legal)
    `ASSERT_IMPLY(a_sign_not_last, i_clk, i_rst_n, !empty && (o_text_char == CHAR_MINUS), !o_last)

endmodule
